### src/mpr_pkg.sv
// ----------------------------------------------------------------------------
// mpr_pkg
// Types and constants shared by the multidrop packet receiver modules.
// ----------------------------------------------------------------------------
package mpr_pkg;

  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_STATION_ADDRESS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_LIMIT     = 8'd1;

  localparam logic [7:0] STATION_ADDRESS_RESET = 8'd1;
  localparam logic [7:0] ERROR_LIMIT_RESET     = 8'd5;
  localparam logic [7:0] TALLY_MAX             = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RX_ADDR = 3'd1,
    PH_TX_ADDR = 3'd2,
    PH_LEN     = 3'd3,
    PH_CMD     = 3'd4,
    PH_ARGS    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] station_address;
    logic [7:0] error_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       address_mark;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [8:0] byte_index;
    logic [7:0] byte_value;
    logic       frame_done;
    logic       in_error;
    logic       limit_hit;
  } result_t;

endpackage

### src/mpr_cfg_regs.sv
// ----------------------------------------------------------------------------
// mpr_cfg_regs
// Configuration register file: station address and error limit.
// ----------------------------------------------------------------------------
module mpr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output mpr_pkg::cfg_t                  cfg
);
  import mpr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_address <= STATION_ADDRESS_RESET;
      cfg.error_limit     <= ERROR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STATION_ADDRESS: cfg.station_address <= cfg_data;
        CFG_ERROR_LIMIT:     cfg.error_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### src/mpr_frame_fsm.sv
// ----------------------------------------------------------------------------
// mpr_frame_fsm
// Frame state and the per-byte update that yields one result.
// ----------------------------------------------------------------------------
module mpr_frame_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mpr_pkg::item_t   item,
  input  mpr_pkg::cfg_t    cfg,
  output mpr_pkg::result_t result
);
  import mpr_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] args_left, args_left_next;
  logic [8:0] write_pos, write_pos_next;
  logic [7:0] error_tally, error_tally_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      args_left   <= '0;
      write_pos   <= '0;
      error_tally <= '0;
    end else if (step) begin
      phase       <= phase_next;
      args_left   <= args_left_next;
      write_pos   <= write_pos_next;
      error_tally <= error_tally_next;
    end
  end

  always_comb begin
    logic       match;
    logic       store;
    logic [8:0] pos;
    match            = (item.rx_byte == cfg.station_address);
    store            = 1'b0;
    phase_next       = phase;
    args_left_next   = args_left;
    pos              = write_pos;
    error_tally_next = error_tally;
    result           = '0;

    if (item.address_mark) begin
      case (phase)
        PH_IDLE: begin
          if (match) begin
            phase_next = PH_RX_ADDR;
            pos        = '0;
          end
        end
        PH_ERROR: begin
          if (match) begin
            phase_next = PH_RX_ADDR;
            pos        = '0;
          end else if (error_tally != TALLY_MAX) begin
            error_tally_next = error_tally + 8'd1;
          end
        end
        default: phase_next = PH_ERROR;
      endcase
    end

    case (phase_next)
      PH_RX_ADDR: begin
        store      = 1'b1;
        phase_next = PH_TX_ADDR;
      end
      PH_TX_ADDR: begin
        store      = 1'b1;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        store          = 1'b1;
        args_left_next = item.rx_byte;
        phase_next     = PH_CMD;
      end
      PH_CMD: begin
        store      = 1'b1;
        phase_next = PH_ARGS;
      end
      PH_ARGS: begin
        store          = 1'b1;
        args_left_next = args_left - 8'd1;
      end
      PH_IDLE, PH_ERROR: ;
      default: phase_next = PH_IDLE;
    endcase

    write_pos_next = pos;
    if (store) begin
      result.byte_valid = 1'b1;
      result.byte_index = pos;
      result.byte_value = item.rx_byte;
      write_pos_next    = pos + 9'd1;
    end

    if (phase_next == PH_ARGS && args_left_next == 8'd0) begin
      result.frame_done = 1'b1;
      phase_next        = PH_IDLE;
      error_tally_next  = '0;
    end else if (error_tally_next >= cfg.error_limit) begin
      result.limit_hit = 1'b1;
      phase_next       = PH_IDLE;
      error_tally_next = '0;
    end

    result.in_error = (phase_next == PH_ERROR);
  end

endmodule

### src/mpr_out_reg.sv
// ----------------------------------------------------------------------------
// mpr_out_reg
// Result register feeding the master stream side.
// ----------------------------------------------------------------------------
module mpr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  mpr_pkg::result_t result,
  output logic             free,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // byte_index[8:0], byte_value[16:9], zero pad
  output logic [2:0]       m_axis_tuser,  // byte_valid[0], in_error[1], limit_hit[2]
  output logic             m_axis_tlast   // frame_done
);
  import mpr_pkg::*;

  result_t held;

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (free) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= result;
    end
  end

  assign m_axis_tdata = {7'd0, held.byte_value, held.byte_index};
  assign m_axis_tuser = {held.limit_hit, held.in_error, held.byte_valid};
  assign m_axis_tlast = held.frame_done;

endmodule

### src/multidrop_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// multidrop_packet_receiver_top
// Multidrop 9-bit-address frame receiver with stream input and output.
// ----------------------------------------------------------------------------
// Accepts one received byte per clock while m_axis_tready does not stall the
// result side, and returns exactly one result per byte through the input
// register, then the result register; the frame state update between them is
// combinational. s_axis_tready follows m_axis_tready combinationally when both
// stages hold data. Configuration writes are always ready and take effect on
// the next cycle; write them only while no byte is in flight.
module multidrop_packet_receiver_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // rx_byte[7:0]
  input  logic [0:0]                      s_axis_tuser,  // address_mark[0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // byte_index[8:0], byte_value[16:9]
  output logic [2:0]                      m_axis_tuser,  // byte_valid, in_error, limit_hit
  output logic                            m_axis_tlast,  // frame_done
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import mpr_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    out_free;
  logic    step;
  result_t result;

  mpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.rx_byte      <= s_axis_tdata;
      in_item.address_mark <= s_axis_tuser[0];
    end
  end

  mpr_frame_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  mpr_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .result        (result),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### src/mpr_checker.sv
// ----------------------------------------------------------------------------
// mpr_checker
// Port-level checks on the result stream of the packet receiver.
// ----------------------------------------------------------------------------
module mpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_done_stored: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && !m_axis_tuser[1]
      && !m_axis_tuser[2])
    else $error("frame done without a stored byte or with error flags");

  a_hit_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tuser[1])
    else $error("limit hit while still in error");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
    else $error("unstored byte carries index or value");

endmodule

bind multidrop_packet_receiver_top mpr_checker u_mpr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/multidrop_packet_receiver_checker.sv
// ----------------------------------------------------------------------------
// multidrop_packet_receiver_checker
// Watches the byte, result and register channels of the multidrop packet
// receiver. Keeps its own copy of the frame state and the station settings,
// works out the report due for every byte transfer and compares each result
// transfer, field by field, with the oldest report still outstanding.
// ----------------------------------------------------------------------------
module multidrop_packet_receiver_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,
  input  logic [0:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [23:0]                     m_axis_tdata,
  input  logic [2:0]                      m_axis_tuser,
  input  logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  output int                              fail_count,
  output int                              outstanding,
  output int                              bytes_in,
  output int                              reports_checked,
  output int                              frames_completed,
  output int                              limit_returns
);
  timeunit 1ns;
  timeprecision 1ps;

  import mpr_pkg::*;

  logic [7:0] station_addr;
  logic [7:0] err_limit;
  phase_t     ph;
  logic [7:0] args_left;
  logic [8:0] write_pos;
  logic [7:0] err_tally;

  result_t expected_reports[$];

  task automatic advance_frame_state(input logic [7:0] b, input logic mark,
                                     output result_t r);
    logic stored;
    r = '0;
    stored = 1'b0;
    if (mark) begin
      if (ph == PH_IDLE) begin
        if (b == station_addr) begin
          ph = PH_RX_ADDR;
          write_pos = '0;
        end
      end else if (ph == PH_ERROR) begin
        if (b == station_addr) begin
          ph = PH_RX_ADDR;
          write_pos = '0;
        end else if (err_tally != TALLY_MAX) begin
          err_tally = err_tally + 8'd1;
        end
      end else begin
        ph = PH_ERROR;
      end
    end

    case (ph)
      PH_RX_ADDR: begin
        stored = 1'b1;
        ph = PH_TX_ADDR;
      end
      PH_TX_ADDR: begin
        stored = 1'b1;
        ph = PH_LEN;
      end
      PH_LEN: begin
        stored = 1'b1;
        args_left = b;
        ph = PH_CMD;
      end
      PH_CMD: begin
        stored = 1'b1;
        ph = PH_ARGS;
      end
      PH_ARGS: begin
        stored = 1'b1;
        args_left = args_left - 8'd1;
      end
      PH_IDLE, PH_ERROR: ;
      default: ph = PH_IDLE;
    endcase

    if (stored) begin
      r.byte_valid = 1'b1;
      r.byte_index = write_pos;
      r.byte_value = b;
      write_pos = write_pos + 9'd1;
    end

    // frame completion takes priority over the limit check
    if (ph == PH_ARGS && args_left == 8'd0) begin
      r.frame_done = 1'b1;
      ph = PH_IDLE;
      err_tally = '0;
    end else if (err_tally >= err_limit) begin
      r.limit_hit = 1'b1;
      ph = PH_IDLE;
      err_tally = '0;
    end
    r.in_error = (ph == PH_ERROR);
  endtask

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      station_addr = STATION_ADDRESS_RESET;
      err_limit    = ERROR_LIMIT_RESET;
      ph           = PH_IDLE;
      args_left    = '0;
      write_pos    = '0;
      err_tally    = '0;
      expected_reports.delete();
      fail_count       = 0;
      bytes_in         = 0;
      reports_checked  = 0;
      frames_completed = 0;
      limit_returns    = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STATION_ADDRESS: station_addr = cfg_data;
          CFG_ERROR_LIMIT:     err_limit = cfg_data;
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_valid = m_axis_tuser[0];
        got.in_error   = m_axis_tuser[1];
        got.limit_hit  = m_axis_tuser[2];
        got.byte_index = m_axis_tdata[8:0];
        got.byte_value = m_axis_tdata[16:9];
        got.frame_done = m_axis_tlast;
        if (got.frame_done) frames_completed++;
        if (got.limit_hit) limit_returns++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual tdata %h tuser %b tlast %b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          fail_count += field_diff("byte_valid", want.byte_valid, got.byte_valid)
                      + field_diff("byte_index", want.byte_index, got.byte_index)
                      + field_diff("byte_value", want.byte_value, got.byte_value)
                      + field_diff("frame_done", want.frame_done, got.frame_done)
                      + field_diff("in_error", want.in_error, got.in_error)
                      + field_diff("limit_hit", want.limit_hit, got.limit_hit);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        advance_frame_state(s_axis_tdata, s_axis_tuser[0], want);
        expected_reports.push_back(want);
        bytes_in++;
      end

      outstanding <= expected_reports.size();
    end
  end

endmodule

### tb/sv/multidrop_packet_receiver_top_test.sv
// ----------------------------------------------------------------------------
// multidrop_packet_receiver_top_test
// Drives the multidrop packet receiver with a directed set of frames, broken
// frames and address errors, then with random traffic under several station
// address and error limit settings, with random gaps on the byte channel and
// random stalls on the result channel. The checker beside the block scores
// every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module multidrop_packet_receiver_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpr_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;
  logic [2:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  int fail_count, outstanding, bytes_in, reports_checked, frames_completed, limit_returns;

  logic [7:0]  cur_station = STATION_ADDRESS_RESET;
  int          counted = 0;
  int          settings_used = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;
  int unsigned stall_left = 0;

  always #5 clk = ~clk;

  multidrop_packet_receiver_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  multidrop_packet_receiver_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .bytes_in         (bytes_in),
    .reports_checked  (reports_checked),
    .frames_completed (frames_completed),
    .limit_returns    (limit_returns)
  );

  // result sink: mostly short stalls, a few long ones
  always @(posedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!sink_steady && r < 25) begin
      m_axis_tready <= 1'b0;
      stall_left <= (r < 21) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (src_steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] other_station();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == cur_station);
    return v;
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 6);
    return $urandom_range(7, 24);
  endfunction

  // valid stays high across back-to-back transfers
  task automatic send_byte(input logic [7:0] b, input logic mark);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= mark;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // cut >= 0: a marked byte replaces the byte at that position and ends the frame
  task automatic send_frame(input int unsigned len, input int cut);
    int pos;
    logic [7:0] b;
    for (pos = 0; pos < int'(len) + 4; pos++) begin
      if (pos == cut) begin
        b = ($urandom_range(0, 3) == 0) ? cur_station : 8'($urandom_range(0, 255));
        send_byte(b, 1'b1);
        counted++;
        return;
      end
      if (pos == 0) b = cur_station;
      else if (pos == 2) b = 8'(len);
      else b = 8'($urandom_range(0, 255));
      send_byte(b, pos == 0);
      counted++;
    end
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] station, input logic [7:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STATION_ADDRESS;
    cfg_data  <= station;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_ERROR_LIMIT;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_station = station;
    settings_used++;
  endtask

  task automatic random_traffic(input int target);
    int unsigned sel, len;
    counted = 0;
    while (counted < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        send_frame(pick_len(), -1);
      end else if (sel < 80) begin
        len = pick_len();
        send_frame(len, $urandom_range(1, len + 3));
      end else if (sel < 92) begin
        send_byte(other_station(), 1'b1);
        counted++;
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  initial begin
    int p;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_config(8'h01, 8'd5);

    // directed: idle noise, zero and one argument frames, error entry,
    // counting in error, restart from error, limit return
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h77, 1'b0);
    send_byte(8'h02, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b1);
    repeat (4) send_byte(8'hFE, 1'b1);
    quiesce();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_config(8'h00, 8'd1);
        1: set_config(8'hFF, 8'd255);
        2: set_config(8'($urandom_range(0, 255)), 8'd3);
        3: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)));
        4: set_config(8'h7E, 8'd2);
        default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
      endcase
      src_steady  <= (p == 3);
      sink_steady <= (p == 4);
      // longest frame: indices run up to 258
      if (p == 1) send_frame(255, -1);
      random_traffic(35);
      quiesce();
    end

    $display("Covered %0d byte transfers and %0d result transfers over %0d register settings",
             bytes_in, reports_checked, settings_used);
    $display("Frames completed: %0d, error limit returns to idle: %0d",
             frames_completed, limit_returns);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout at %0t, %0d results still outstanding", $time, outstanding);
    $display("Regression FAIL");
    $finish;
  end

endmodule
